FILE: rtl/ovi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ovi_pkg: shared types and constants for the octree voxel insert block
// Child codes, result codes, controller states and the command and status
// groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
package ovi_pkg;

    localparam int DEF_NODE_CAPACITY = 4096;
    localparam int MAX_LEVELS        = 10;
    localparam int GRID_RESET        = 10;

    localparam int LEVEL_W     = 4;
    localparam int COORD_W     = 10;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 13;

    // child word codes
    localparam int CODE_AIR  = 0;
    localparam int CODE_FULL = 1;
    localparam int CODE_BASE = 2;

    typedef enum logic [STATUS_W-1:0] {
        STS_SET          = 2'd0,
        STS_ALREADY_FULL = 2'd1,
        STS_DROPPED      = 2'd2,
        STS_OUTSIDE      = 2'd3
    } ovi_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_EVAL,
        ST_CLEAR,
        ST_DONE
    } ovi_state_t;

    typedef struct packed {
        logic        load;
        logic        read;
        logic        mark_full;
        logic        alloc;
        logic        descend;
        logic        clear;
        logic        set_result;
        ovi_status_t result;
        logic        finish;
    } ovi_cmd_t;

    typedef struct packed {
        logic oob;
        logic code_full;
        logic code_air;
        logic lvl_zero;
        logic pool_full;
        logic clr_last;
        logic out_free;
    } ovi_flag_t;

endpackage : ovi_pkg
`default_nettype wire

FILE: rtl/ovi_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ovi_ctrl: walk controller
// Sequences the grid check, one read and decision per level, the clearing
// of a freshly allocated node and the hand-off of the result.
// ----------------------------------------------------------------------------
module ovi_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire ovi_pkg::ovi_flag_t flag,
    output ovi_pkg::ovi_cmd_t      cmd
);
    import ovi_pkg::*;

    ovi_state_t state_reg;
    ovi_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.result = STS_SET;
        in_stall   = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (flag.oob)
                begin
                    cmd.set_result = 1'b1;
                    cmd.result     = STS_OUTSIDE;
                    state_next     = ST_DONE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (flag.code_full)
                begin
                    cmd.set_result = 1'b1;
                    cmd.result     = STS_ALREADY_FULL;
                    state_next     = ST_DONE;
                end
                else if (flag.lvl_zero)
                begin
                    cmd.mark_full  = 1'b1;
                    cmd.set_result = 1'b1;
                    cmd.result     = STS_SET;
                    state_next     = ST_DONE;
                end
                else if (flag.code_air)
                begin
                    if (flag.pool_full)
                    begin
                        cmd.set_result = 1'b1;
                        cmd.result     = STS_DROPPED;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        cmd.alloc  = 1'b1;
                        state_next = ST_CLEAR;
                    end
                end
                else
                begin
                    cmd.descend = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (flag.clr_last)
                begin
                    state_next = ST_READ;
                end
            end
            ST_DONE:
            begin
                if (flag.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule : ovi_ctrl
`default_nettype wire

FILE: rtl/ovi_path.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ovi_path: walk datapath
// Holds the child word memory, the node counter, the walk position, the
// grid register and the output register.
// ----------------------------------------------------------------------------
module ovi_path #(
    parameter int NODE_CAPACITY = ovi_pkg::DEF_NODE_CAPACITY
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [ovi_pkg::LEVEL_W-1:0]    grid_levels,
    input  wire logic [ovi_pkg::COORD_W-1:0]    coord_x,
    input  wire logic [ovi_pkg::COORD_W-1:0]    coord_y,
    input  wire logic [ovi_pkg::COORD_W-1:0]    coord_z,
    input  wire ovi_pkg::ovi_cmd_t              cmd,
    output ovi_pkg::ovi_flag_t                  flag,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [ovi_pkg::STATUS_W-1:0]        insert_status,
    output logic [ovi_pkg::COUNT_OUT_W-1:0]     nodes_in_use
);
    import ovi_pkg::*;

    localparam int NODE_W = $clog2(NODE_CAPACITY);
    localparam int CNT_W  = $clog2(NODE_CAPACITY + 1);
    localparam int CODE_W = $clog2(NODE_CAPACITY + CODE_BASE);
    localparam int ADDR_W = NODE_W + 3;
    localparam int DEPTH  = NODE_CAPACITY * 8;

    logic [LEVEL_W-1:0] grid_reg;
    logic [LEVEL_W-1:0] eff_levels;
    logic [LEVEL_W-1:0] levels_reg;
    logic [LEVEL_W-1:0] lvl_reg;
    logic [COORD_W-1:0] coord_x_reg;
    logic [COORD_W-1:0] coord_y_reg;
    logic [COORD_W-1:0] coord_z_reg;
    logic [NODE_W-1:0]  node_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [2:0]         clr_cnt_reg;
    logic [7:0]         root_valid_reg;
    ovi_status_t        result_reg;
    logic               out_valid_reg;
    ovi_status_t        status_out_reg;
    logic [COUNT_OUT_W-1:0] count_out_reg;

    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] sz;
    logic [2:0]         child;
    logic               at_root;
    logic [CODE_W-1:0]  rdata_reg;
    logic [CODE_W-1:0]  code;
    logic [CODE_W-1:0]  ptr;
    logic [NODE_W-1:0]  ptr_node;
    logic               oob;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic [CODE_W-1:0]  mem_wdata;
    logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

    logic [CODE_W-1:0] mem [0:DEPTH-1];

    // clamp the configured depth into the supported range
    always_comb
    begin
        if (grid_reg == '0)
        begin
            eff_levels = LEVEL_W'(1);
        end
        else if (int'(grid_reg) > MAX_LEVELS)
        begin
            eff_levels = LEVEL_W'(MAX_LEVELS);
        end
        else
        begin
            eff_levels = grid_reg;
        end
    end

    always_comb
    begin
        oob = 1'b0;
        for (int i = 0; i < COORD_W; i++)
        begin
            if (i >= int'(levels_reg) && (coord_x_reg[i] | coord_y_reg[i] | coord_z_reg[i]))
            begin
                oob = 1'b1;
            end
        end
    end

    assign sx    = coord_x_reg >> lvl_reg;
    assign sy    = coord_y_reg >> lvl_reg;
    assign sz    = coord_z_reg >> lvl_reg;
    assign child = {sz[0], sy[0], sx[0]};

    // root words are never swept, so an unwritten root child reads as air
    assign at_root = (node_reg == '0);
    assign code    = (at_root && !root_valid_reg[child]) ? CODE_W'(CODE_AIR) : rdata_reg;
    assign ptr     = code - CODE_W'(CODE_BASE);

    always_comb
    begin
        if (int'(ptr) >= NODE_CAPACITY)
        begin
            ptr_node = '0;
        end
        else
        begin
            ptr_node = ptr[NODE_W-1:0];
        end
    end

    assign mem_we   = cmd.mark_full | cmd.alloc | cmd.clear;
    assign mem_addr = cmd.clear ? {node_reg, clr_cnt_reg} : {node_reg, child};

    always_comb
    begin
        if (cmd.alloc)
        begin
            mem_wdata = CODE_W'(count_reg) + CODE_W'(CODE_BASE);
        end
        else if (cmd.mark_full)
        begin
            mem_wdata = CODE_W'(CODE_FULL);
        end
        else
        begin
            mem_wdata = CODE_W'(CODE_AIR);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (cmd.read)
        begin
            rdata_reg <= mem[mem_addr];
        end
    end

    // walk position and payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            coord_x_reg <= coord_x;
            coord_y_reg <= coord_y;
            coord_z_reg <= coord_z;
            levels_reg  <= eff_levels;
            lvl_reg     <= eff_levels - LEVEL_W'(1);
            node_reg    <= '0;
        end
        else if (cmd.alloc)
        begin
            lvl_reg  <= lvl_reg - LEVEL_W'(1);
            node_reg <= count_reg[NODE_W-1:0];
        end
        else if (cmd.descend)
        begin
            lvl_reg  <= lvl_reg - LEVEL_W'(1);
            node_reg <= ptr_node;
        end
        if (cmd.alloc)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + 3'd1;
        end
        if (cmd.set_result)
        begin
            result_reg <= cmd.result;
        end
        if (cmd.finish)
        begin
            status_out_reg <= result_reg;
            count_out_reg  <= count_ext[COUNT_OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_reg       <= LEVEL_W'(GRID_RESET);
            count_reg      <= CNT_W'(1);
            root_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                grid_reg <= grid_levels;
            end
            if (cmd.alloc)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if ((cmd.alloc || cmd.mark_full) && at_root)
            begin
                root_valid_reg[child] <= 1'b1;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign count_ext = {{COUNT_OUT_W{1'b0}}, count_reg};

    assign flag.oob       = oob;
    assign flag.code_full = (code == CODE_W'(CODE_FULL));
    assign flag.code_air  = (code == CODE_W'(CODE_AIR));
    assign flag.lvl_zero  = (lvl_reg == '0);
    assign flag.pool_full = (count_reg >= CNT_W'(NODE_CAPACITY));
    assign flag.clr_last  = (clr_cnt_reg == 3'd7);
    assign flag.out_free  = !out_valid_reg || !out_stall;

    assign out_valid     = out_valid_reg;
    assign insert_status = status_out_reg;
    assign nodes_in_use  = count_out_reg;

endmodule : ovi_path
`default_nettype wire

FILE: rtl/octree_voxel_insert.sv
`default_nettype none
// walk: each level walked takes a memory read and a decision, and each allocated node
//   has its eight child words swept through the single memory port before the walk goes on;
//   an out-of-grid coordinate is caught in the grid check, before any memory read
// one item at a time: the input stalls from accept until the result is handed off
// reset: clears control, node count to one and depth to 10; root children read as air
//   through per-child valid bits, so no clearing pass runs
// ----------------------------------------------------------------------------
// octree_voxel_insert: sparse voxel octree insert
// Walks the node pool from the root, allocates nodes for air children and
// marks the leaf voxel full, returning a status and the node count.
// ----------------------------------------------------------------------------
module octree_voxel_insert #(
    parameter int NODE_CAPACITY = ovi_pkg::DEF_NODE_CAPACITY
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [ovi_pkg::LEVEL_W-1:0]    grid_levels,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [ovi_pkg::COORD_W-1:0]    coord_x,
    input  wire logic [ovi_pkg::COORD_W-1:0]    coord_y,
    input  wire logic [ovi_pkg::COORD_W-1:0]    coord_z,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [ovi_pkg::STATUS_W-1:0]        insert_status,
    output logic [ovi_pkg::COUNT_OUT_W-1:0]     nodes_in_use
);
    import ovi_pkg::*;

    ovi_cmd_t  cmd;
    ovi_flag_t flag;

    ovi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .flag     (flag),
        .cmd      (cmd)
    );

    ovi_path #(
        .NODE_CAPACITY (NODE_CAPACITY)
    ) u_path (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .grid_levels   (grid_levels),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .coord_z       (coord_z),
        .cmd           (cmd),
        .flag          (flag),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .insert_status (insert_status),
        .nodes_in_use  (nodes_in_use)
    );

endmodule : octree_voxel_insert
`default_nettype wire

FILE: rtl/ovi_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ovi_port_checks: port-level checks for the octree voxel insert block
// Watches the handshakes and result ordering seen at the top level.
// ----------------------------------------------------------------------------
module ovi_port_checks (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_stall,
    input wire logic                            out_valid,
    input wire logic                            out_stall,
    input wire logic [ovi_pkg::STATUS_W-1:0]    insert_status,
    input wire logic [ovi_pkg::COUNT_OUT_W-1:0] nodes_in_use
);
    import ovi_pkg::*;

    // a waiting result holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(insert_status) && $stable(nodes_in_use))
        else $error("result changed while stalled");

    // an accepted item keeps the block busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after accept");

    // no result can appear in the cycle right after an accept
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result too early");

    // a new result only comes from an item that was in progress
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without an item in progress");

endmodule : ovi_port_checks

bind octree_voxel_insert ovi_port_checks u_ovi_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .insert_status (insert_status),
    .nodes_in_use  (nodes_in_use)
);
`default_nettype wire
